// ----- design/dfst_pkg.sv -----
// Shared types and constants for the depth-first spanning tree block.
package dfst_pkg;

    // Fixed field widths of the stream items
    localparam int VTX_W       = 7;
    localparam int IDX_W       = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Input selector codes carried on tuser
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_SCAN,
        S_PICK,
        S_POP,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic edge_start;  // latch endpoints, read row of first endpoint
        logic edge_wr_a;   // write first row, read second row
        logic edge_wr_b;   // write second row
        logic walk_start;  // seed the walk from a valid start vertex
        logic walk_skip;   // run with a bad start vertex
        logic scan;        // register lowest unvisited neighbor
        logic emit;        // take the tree edge and push
        logic pop;         // drop top, read next entry of the stack
        logic pop_load;    // load new top, read its row
        logic finish;      // send the final result, clear the graph
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_func;
        logic in_edge_ok;
        logic in_start_ok;
        logic cand_nz;
        logic depth_one;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

// ----- design/dfst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dfst_ram
    #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
    )
    (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dfst_datapath.sv -----
// Datapath: adjacency rows, visited marks, vertex stack and result registers.
module dfst_datapath
    import dfst_pkg::*;
    #(
    parameter int MAX_VERTICES = 64
    )
    (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_in_func,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic                   o_out_user,
    output logic                   o_out_last
    );

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam logic [VTX_W-1:0] VMAX = VTX_W'(MAX_VERTICES);
    localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

    logic [VTX_W-1:0] in_first;
    logic [VTX_W-1:0] in_second;
    logic [VTX_W-1:0] first_m1;
    logic [VTX_W-1:0] second_m1;
    logic             first_ok;
    logic             second_ok;

    logic [VW-1:0]           r_a;
    logic [VW-1:0]           r_b;
    logic [MAX_VERTICES-1:0] r_row_valid;
    logic                    r_rd_valid;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [VW-1:0]           r_top;
    logic [DW-1:0]           r_depth;
    logic [IDX_W-1:0]        r_edge_count;
    logic [MAX_VERTICES-1:0] r_onehot;
    logic                    r_cand_nz;

    logic                    r_pend_valid;
    logic [VTX_W-1:0]        r_pend_parent;
    logic [VTX_W-1:0]        r_pend_child;
    logic [IDX_W-1:0]        r_pend_idx;

    logic                    r_out_valid;
    logic [VTX_W-1:0]        r_out_parent;
    logic [VTX_W-1:0]        r_out_child;
    logic [IDX_W-1:0]        r_out_idx;
    logic                    r_out_has;
    logic                    r_out_last;

    logic [MAX_VERTICES-1:0] adj_q;
    logic [MAX_VERTICES-1:0] rd_row;
    logic [VW-1:0]           adj_raddr;
    logic [VW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic                    adj_we;
    logic [MAX_VERTICES-1:0] cand;
    logic [VW-1:0]           v_idx;
    logic [VW-1:0]           stk_q;
    logic [DW-1:0]           depth_m1;
    logic [DW-1:0]           depth_m2;
    logic                    out_free;

    assign in_first  = i_in_data[VTX_W-1:0];
    assign in_second = i_in_data[2*VTX_W-1:VTX_W];
    assign first_m1  = in_first - VTX_W'(1);
    assign second_m1 = in_second - VTX_W'(1);
    assign first_ok  = (in_first != '0) && (in_first <= VMAX);
    assign second_ok = (in_second != '0) && (in_second <= VMAX);

    // Row not written since the last clear reads as zero
    assign rd_row = r_rd_valid ? adj_q : '0;
    assign cand   = rd_row & ~r_visited;

    // Encode the registered one-hot neighbor into an index
    always_comb begin
        v_idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (r_onehot[i]) begin
                v_idx = v_idx | VW'(i);
            end
        end
    end

    always_comb begin
        adj_raddr = r_top;
        if (i_cmd.edge_start || i_cmd.walk_start) begin
            adj_raddr = first_m1[VW-1:0];
        end else if (i_cmd.edge_wr_a) begin
            adj_raddr = r_b;
        end else if (i_cmd.emit) begin
            adj_raddr = v_idx;
        end else if (i_cmd.pop_load) begin
            adj_raddr = stk_q;
        end
    end

    assign adj_we    = i_cmd.edge_wr_a || i_cmd.edge_wr_b;
    assign adj_waddr = i_cmd.edge_wr_a ? r_a : r_b;
    assign adj_wdata = rd_row | (i_cmd.edge_wr_a ? (ONE << r_b) : (ONE << r_a));

    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);

    dfst_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_q)
    );

    dfst_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.emit),
        .i_waddr (depth_m1[VW-1:0]),
        .i_wdata (r_top),
        .i_raddr (depth_m2[VW-1:0]),
        .o_rdata (stk_q)
    );

    assign out_free = !r_out_valid || i_out_ready;

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_row_valid[adj_raddr];
        if (i_cmd.edge_start) begin
            r_a <= first_m1[VW-1:0];
            r_b <= second_m1[VW-1:0];
        end
        if (i_cmd.scan) begin
            r_onehot  <= cand & (~cand + ONE);
            r_cand_nz <= (cand != '0);
        end
        if (i_cmd.walk_start) begin
            r_top <= first_m1[VW-1:0];
        end else if (i_cmd.emit) begin
            r_top <= v_idx;
        end else if (i_cmd.pop_load) begin
            r_top <= stk_q;
        end
        if (i_cmd.emit) begin
            r_pend_parent <= VTX_W'(r_top) + VTX_W'(1);
            r_pend_child  <= VTX_W'(v_idx) + VTX_W'(1);
            r_pend_idx    <= r_edge_count;
        end
        if (i_cmd.emit && r_pend_valid) begin
            r_out_parent <= r_pend_parent;
            r_out_child  <= r_pend_child;
            r_out_idx    <= r_pend_idx;
            r_out_has    <= 1'b1;
            r_out_last   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_parent <= r_pend_valid ? r_pend_parent : '0;
            r_out_child  <= r_pend_valid ? r_pend_child : '0;
            r_out_idx    <= r_pend_valid ? r_pend_idx : '0;
            r_out_has    <= r_pend_valid;
            r_out_last   <= 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid  <= '0;
            r_visited    <= '0;
            r_depth      <= '0;
            r_edge_count <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.edge_wr_a) begin
                r_row_valid[r_a] <= 1'b1;
            end else if (i_cmd.edge_wr_b) begin
                r_row_valid[r_b] <= 1'b1;
            end else if (i_cmd.finish) begin
                r_row_valid <= '0;
            end

            if (i_cmd.walk_start) begin
                r_visited <= ONE << first_m1[VW-1:0];
            end else if (i_cmd.emit) begin
                r_visited <= r_visited | r_onehot;
            end else if (i_cmd.finish) begin
                r_visited <= '0;
            end

            if (i_cmd.walk_start) begin
                r_depth <= DW'(1);
            end else if (i_cmd.emit) begin
                r_depth <= r_depth + DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= depth_m1;
            end

            if (i_cmd.walk_start) begin
                r_edge_count <= '0;
            end else if (i_cmd.emit) begin
                r_edge_count <= r_edge_count + IDX_W'(1);
            end

            if (i_cmd.walk_start || i_cmd.walk_skip || i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end

            if ((i_cmd.emit && r_pend_valid) || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.in_func     = i_in_func;
    assign o_status.in_edge_ok  = first_ok && second_ok;
    assign o_status.in_start_ok = first_ok;
    assign o_status.cand_nz     = r_cand_nz;
    assign o_status.depth_one   = (r_depth == DW'(1));
    assign o_status.pend_valid  = r_pend_valid;
    assign o_status.out_free    = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_TDATA_W - 2*VTX_W - IDX_W){1'b0}},
                          r_out_idx, r_out_child, r_out_parent};
    assign o_out_user  = r_out_has;
    assign o_out_last  = r_out_last;

endmodule

// ----- design/dfst_ctrl.sv -----
// Controller state machine sequencing edge loads and the depth-first walk.
module dfst_ctrl
    import dfst_pkg::*;
    (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
    );

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_status.in_func == FUNC_EDGE) begin
                        n_state = i_status.in_edge_ok ? S_EDGE_A : S_IDLE;
                    end else begin
                        n_state = i_status.in_start_ok ? S_SCAN : S_DONE;
                    end
                end
            end
            S_EDGE_A: n_state = S_EDGE_B;
            S_EDGE_B: n_state = S_IDLE;
            S_SCAN:   n_state = S_PICK;
            S_PICK: begin
                if (i_status.cand_nz) begin
                    if (!i_status.pend_valid || i_status.out_free) begin
                        n_state = S_SCAN;
                    end
                end else begin
                    n_state = i_status.depth_one ? S_DONE : S_POP;
                end
            end
            S_POP:  n_state = S_SCAN;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    if (i_status.in_func == FUNC_EDGE) begin
                        o_cmd.edge_start = i_status.in_edge_ok;
                    end else begin
                        o_cmd.walk_start = i_status.in_start_ok;
                        o_cmd.walk_skip  = !i_status.in_start_ok;
                    end
                end
            end
            S_EDGE_A: o_cmd.edge_wr_a = 1'b1;
            S_EDGE_B: o_cmd.edge_wr_b = 1'b1;
            S_SCAN:   o_cmd.scan = 1'b1;
            S_PICK: begin
                if (i_status.cand_nz) begin
                    o_cmd.emit = !i_status.pend_valid || i_status.out_free;
                end else begin
                    o_cmd.pop = !i_status.depth_one;
                end
            end
            S_POP:  o_cmd.pop_load = 1'b1;
            S_DONE: o_cmd.finish = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- design/dfs_spanning_tree.sv -----
// An edge transfer is accepted, then both rows are read-modify-written in turn; an edge
// with a bad endpoint is dropped in its accept cycle. A run is accepted, then each tree
// edge takes a row read and a pick, each backtrack a row read, a pick and a stack read,
// the last check at the start vertex a row read and a pick, then the last result is sent.
// Throughput: one item at a time; tready is low until the item is done, a stalled result
// holds the walk. Reset: synchronous, active low; clears state, valid bits, visited marks.
module dfs_spanning_tree
    import dfst_pkg::*;
    #(
    parameter int MAX_VERTICES = 64
    )
    (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side: edge or run requests
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [6:0] first_vertex, [13:7] second_vertex
    input  logic                   s_axis_tuser,  // [0] func
    // master side: tree edges in discovery order
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [6:0] parent, [13:7] child, [19:14] edge_index
    output logic                   m_axis_tuser,  // [0] has_edge
    output logic                   m_axis_tlast
    );

    t_cmd    cmd;
    t_status status;

    // The datapath holds the adjacency rows in RAM with one valid bit per row,
    // so the graph is cleared by clearing the valid bits. The walk keeps the top
    // of the stack in a register; the entries below it sit in a small RAM. Each
    // tree edge is held back one step so the final one can carry tlast.
    dfst_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_func   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    // The controller accepts a transfer only when idle and steps the walk:
    // scan a row, pick the lowest unvisited neighbor, push or pop.
    dfst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

endmodule

// ----- design/dfst_checker.sv -----
// Port-level checker for the spanning tree block, bound to the top level.
module dfst_checker
    import dfst_pkg::*;
    (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
    );

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Empty result is the only one of its run and carries zeros
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty result malformed");

    // A tree edge joins two distinct vertices
    a_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[6:0] != '0)
            && (m_axis_tdata[13:7] != '0) && (m_axis_tdata[6:0] != m_axis_tdata[13:7]))
        else $error("tree edge endpoints invalid");

    // Hold off new requests while a run still has results to come
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("request taken during a run");

endmodule

bind dfs_spanning_tree dfst_checker u_dfst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/tb_dfs_spanning_tree.sv -----
// Self-checking testbench for the depth-first spanning tree block.
`timescale 1ns / 100ps

module tb_dfs_spanning_tree;
    import dfst_pkg::*;

    localparam int MAX_VTX     = 64;
    localparam int ITEM_TARGET = 250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;
    localparam int IDLE_PCT    = 37;

    // One result transfer, fields in the order they sit on the bus
    typedef struct packed {
        logic [VTX_W-1:0] parent;
        logic [VTX_W-1:0] child;
        logic [IDX_W-1:0] idx;
        logic             has_edge;
        logic             last;
    } t_tree_result;

    // One directed stimulus row; want is used only when typed is set
    typedef struct packed {
        logic             fn;
        logic [VTX_W-1:0] va;
        logic [VTX_W-1:0] vb;
        logic             typed;
        t_tree_result     want;
    } t_stim_row;

    localparam t_tree_result NO_EDGE  = '{7'd0, 7'd0, 6'd0, 1'b0, 1'b1};
    localparam t_tree_result ONE_EDGE = '{7'd64, 7'd1, 6'd0, 1'b1, 1'b1};
    localparam t_tree_result UNUSED   = '0;
    localparam int           N_ROWS   = 23;

    localparam t_stim_row DIRECTED [N_ROWS] = '{
        '{FUNC_RUN,  7'd1,   7'd0,   1'b1, NO_EDGE},  // run right after reset
        '{FUNC_RUN,  7'd0,   7'd0,   1'b1, NO_EDGE},  // start vertex zero
        '{FUNC_RUN,  7'd127, 7'd127, 1'b1, NO_EDGE},  // start vertex all ones
        '{FUNC_RUN,  7'd65,  7'd1,   1'b1, NO_EDGE},  // start just past the top
        '{FUNC_EDGE, 7'd0,   7'd5,   1'b0, UNUSED},   // endpoint zero, dropped
        '{FUNC_EDGE, 7'd5,   7'd65,  1'b0, UNUSED},   // endpoint too high, dropped
        '{FUNC_EDGE, 7'd127, 7'd0,   1'b0, UNUSED},   // both bad, dropped
        '{FUNC_RUN,  7'd5,   7'd0,   1'b1, NO_EDGE},  // dropped edges left nothing
        '{FUNC_EDGE, 7'd64,  7'd1,   1'b0, UNUSED},   // extreme vertices
        '{FUNC_RUN,  7'd64,  7'd0,   1'b1, ONE_EDGE},
        '{FUNC_EDGE, 7'd3,   7'd3,   1'b0, UNUSED},   // self loop alone
        '{FUNC_RUN,  7'd3,   7'd0,   1'b1, NO_EDGE},
        '{FUNC_EDGE, 7'd3,   7'd4,   1'b0, UNUSED},
        '{FUNC_EDGE, 7'd4,   7'd3,   1'b0, UNUSED},   // repeated, reversed
        '{FUNC_EDGE, 7'd3,   7'd4,   1'b0, UNUSED},   // repeated again
        '{FUNC_EDGE, 7'd4,   7'd2,   1'b0, UNUSED},
        '{FUNC_EDGE, 7'd2,   7'd64,  1'b0, UNUSED},
        '{FUNC_EDGE, 7'd1,   7'd3,   1'b0, UNUSED},
        '{FUNC_EDGE, 7'd3,   7'd64,  1'b0, UNUSED},   // closes a cycle, forces backtrack
        '{FUNC_RUN,  7'd3,   7'd127, 1'b0, UNUSED},   // second field ignored on a run
        '{FUNC_EDGE, 7'd10,  7'd20,  1'b0, UNUSED},
        '{FUNC_RUN,  7'd11,  7'd0,   1'b1, NO_EDGE},  // isolated start vertex
        '{FUNC_RUN,  7'd10,  7'd0,   1'b1, NO_EDGE}   // graph was cleared by last run
    };

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [6:0] first_vertex, [13:7] second_vertex
    logic                   s_axis_tuser  = 1'b0; // [0] func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [6:0] parent, [13:7] child, [19:14] edge_index
    logic                   m_axis_tuser;  // [0] has_edge
    logic                   m_axis_tlast;

    // Shadow graph and pending results
    logic [MAX_VTX-1:0] adj_rows [MAX_VTX];
    t_tree_result       walk_result [$];
    t_tree_result       edges_due [$];

    bit calm = 1'b0;      // when set, neither side idles
    int sent_items   = 0;
    int walks_sent   = 0;
    int edges_sent   = 0;
    int results_seen = 0;
    int edge_results = 0;
    int errors       = 0;
    int cycles       = 0;

    dfs_spanning_tree #(
        .MAX_VERTICES (MAX_VTX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, edges_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: stall at random except inside the calm window
    always @(posedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic bit vertex_valid(logic [VTX_W-1:0] v);
        return v >= 1 && v <= MAX_VTX;
    endfunction

    // Apply one item to the shadow graph; a walk leaves its transfers in walk_result
    task automatic grow_or_walk(input logic fn, input logic [VTX_W-1:0] va,
                                input logic [VTX_W-1:0] vb);
        logic [MAX_VTX-1:0] seen;
        logic [MAX_VTX-1:0] cand;
        logic [5:0]         stack [MAX_VTX];
        logic [IDX_W-1:0]   found;
        t_tree_result       res;
        int                 depth;
        int                 u;
        int                 v;
        walk_result.delete();
        if (fn == FUNC_EDGE) begin
            if (vertex_valid(va) && vertex_valid(vb)) begin
                adj_rows[va - 1][vb - 1] = 1'b1;
                adj_rows[vb - 1][va - 1] = 1'b1;
            end
            return;
        end
        if (vertex_valid(va)) begin
            seen        = '0;
            seen[va - 1] = 1'b1;
            stack[0]    = 6'(va - 1);
            depth       = 1;
            found       = '0;
            while (depth > 0) begin
                u    = stack[depth - 1];
                cand = adj_rows[u] & ~seen;
                if (cand == '0) begin
                    depth--;      // dead end, back up one level
                end else begin
                    v = 0;
                    while (!cand[v]) v++;
                    seen[v] = 1'b1;
                    if (walk_result.size() < 63) begin
                        res         = '{7'(u + 1), 7'(v + 1), found, 1'b1, 1'b0};
                        walk_result = {walk_result, res};
                    end
                    found++;
                    if (depth < MAX_VTX) begin
                        stack[depth] = 6'(v);
                        depth++;
                    end
                end
            end
        end
        if (walk_result.size() == 0) begin
            walk_result = {walk_result, NO_EDGE};
        end else begin
            walk_result[walk_result.size() - 1].last = 1'b1;
        end
        foreach (adj_rows[i]) adj_rows[i] = '0;  // a run wipes the graph
    endtask

    // Queue what the item should produce, then hold it on the bus until the transfer
    task automatic send_item(input logic fn, input logic [VTX_W-1:0] va,
                             input logic [VTX_W-1:0] vb, input logic typed,
                             input t_tree_result want);
        grow_or_walk(fn, va, vb);
        if (fn == FUNC_RUN) begin
            walks_sent++;
            if (typed) edges_due = {edges_due, want};
            else edges_due = {edges_due, walk_result};
        end else begin
            edges_sent++;
        end
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {2'b00, vb, va};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_items++;
    endtask

    function automatic logic [VTX_W-1:0] bad_vertex();
        return ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom_range(MAX_VTX + 1, 127));
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Compare every output transfer with the oldest pending result
    always @(posedge i_clk) begin : score
        t_tree_result got;
        t_tree_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[6:0], m_axis_tdata[13:7], m_axis_tdata[19:14],
                    m_axis_tuser, m_axis_tlast};
            results_seen++;
            if (got.has_edge) edge_results++;
            if (edges_due.size() == 0) begin
                $error("unexpected result: parent %0d child %0d index %0d",
                       got.parent, got.child, got.idx);
                errors++;
            end else begin
                want = edges_due.pop_front();
                check_field("parent_vertex", want.parent,   got.parent);
                check_field("child_vertex",  want.child,    got.child);
                check_field("edge_index",    want.idx,      got.idx);
                check_field("has_edge",      want.has_edge, got.has_edge);
                check_field("last",          want.last,     got.last);
            end
        end
    end

    initial begin : stimulus
        logic [VTX_W-1:0] order [MAX_VTX];
        logic [VTX_W-1:0] va;
        logic [VTX_W-1:0] vb;
        logic [VTX_W-1:0] swap;
        int               nv;
        int               base;
        int               ne;
        int               j;
        bit               big_done;
        big_done = 1'b0;
        foreach (adj_rows[i]) adj_rows[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: bad vertices, self loops, repeats, backtracking
        for (int r = 0; r < N_ROWS; r++)
            send_item(DIRECTED[r].fn, DIRECTED[r].va, DIRECTED[r].vb,
                      DIRECTED[r].typed, DIRECTED[r].want);

        // Random graphs, each closed by a walk; one pass covers all 64 vertices
        while (sent_items < ITEM_TARGET) begin
            calm = (sent_items >= 150 && sent_items < 200);
            if (!big_done && sent_items >= 100) begin
                big_done = 1'b1;
                foreach (order[i]) order[i] = 7'(i + 1);
                for (int i = MAX_VTX - 1; i > 0; i--) begin
                    j        = $urandom_range(i);
                    swap     = order[i];
                    order[i] = order[j];
                    order[j] = swap;
                end
                // A shuffled path spans every vertex, a few chords add branching
                for (int i = 0; i < MAX_VTX - 1; i++)
                    send_item(FUNC_EDGE, order[i], order[i + 1], 1'b0, UNUSED);
                repeat (6)
                    send_item(FUNC_EDGE, 7'($urandom_range(1, MAX_VTX)),
                              7'($urandom_range(1, MAX_VTX)), 1'b0, UNUSED);
                send_item(FUNC_RUN, order[$urandom_range(MAX_VTX - 1)],
                          7'($urandom_range(127)), 1'b0, UNUSED);
            end else begin
                nv   = $urandom_range(2, 10);
                base = $urandom_range(1, MAX_VTX + 1 - nv);
                ne   = $urandom_range(1, 2 * nv);
                repeat (ne) begin
                    va = 7'(base + $urandom_range(nv - 1));
                    vb = 7'(base + $urandom_range(nv - 1));
                    if ($urandom_range(11) == 0) begin
                        if ($urandom_range(1)) va = bad_vertex();
                        else vb = bad_vertex();
                    end
                    send_item(FUNC_EDGE, va, vb, 1'b0, UNUSED);
                end
                case ($urandom_range(9))
                    0:       va = bad_vertex();
                    1:       va = 7'($urandom_range(1, MAX_VTX));
                    default: va = 7'(base + $urandom_range(nv - 1));
                endcase
                send_item(FUNC_RUN, va, 7'($urandom_range(127)), 1'b0, UNUSED);
            end
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray transfer
        while (edges_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d items sent: %0d edge loads, %0d walks",
                 sent_items, edges_sent, walks_sent);
        $display("%0d results checked, %0d of them tree edges, %0d errors",
                 results_seen, edge_results, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
